/* src/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, idle while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check on clk that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, constants and the alphabet lookup of the base64 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned SEXTET_W = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned QUEUE_D  = 4;
  localparam int unsigned CNT_W    = 3;

  localparam logic [SEXTET_W-1:0] SEXTET_BAD   = 7'd64;
  localparam logic [SEXTET_W-1:0] SEXTET_PLUS  = 7'd62;
  localparam logic [SEXTET_W-1:0] SEXTET_SLASH = 7'd63;
  localparam logic [SEXTET_W-1:0] SEXTET_DIGIT = 7'd52;
  localparam logic [SEXTET_W-1:0] SEXTET_LOWER = 7'd26;

  localparam logic [1:0] QUAD_LAST = 2'd3;

  // one decoded result
  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              last_byte;
    logic              length_error;
  } res_t;

  // results produced by one accepted symbol
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      item;
  } push_t;

  // standard alphabet, anything else maps to the invalid marker
  function automatic logic [SEXTET_W-1:0] sextet_of(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] d;
    d = '0;
    if (s inside {[8'h41:8'h5A]}) begin
      d = s - 8'h41;
      return d[SEXTET_W-1:0];
    end else if (s inside {[8'h61:8'h7A]}) begin
      d = s - 8'h61;
      return d[SEXTET_W-1:0] + SEXTET_LOWER;
    end else if (s inside {[8'h30:8'h39]}) begin
      d = s - 8'h30;
      return d[SEXTET_W-1:0] + SEXTET_DIGIT;
    end else if (s == 8'h2B) begin
      return SEXTET_PLUS;
    end else if (s == 8'h2F) begin
      return SEXTET_SLASH;
    end
    return SEXTET_BAD;
  endfunction

endpackage

`default_nettype wire

/* src/b64d_outq.sv */
// ----------------------------------------------------------------------------
// b64d_outq
// small shifting result queue, takes up to three results per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_outq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire b64d_pkg::push_t         push,
  output      logic [b64d_pkg::CNT_W-1:0] level,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      b64d_pkg::res_t          out_item
);
  import b64d_pkg::*;

  `include "assert_macros.svh"

  res_t             q_r   [QUEUE_D];
  res_t             q_nxt [QUEUE_D];
  res_t             q_shift [QUEUE_D];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] j;
  logic             pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_item  = q_r[0];
  assign level     = cnt_r;

  always_comb begin
    base    = cnt_r - CNT_W'(pop);
    cnt_nxt = base + CNT_W'(push.cnt);
    j       = '0;
    for (int i = 0; i < QUEUE_D; i++) begin
      if (pop && i < QUEUE_D - 1) begin
        q_shift[i] = q_r[i+1];
      end else begin
        q_shift[i] = q_r[i];
      end
    end
    for (int i = 0; i < QUEUE_D; i++) begin
      q_nxt[i] = q_shift[i];
      if (CNT_W'(i) >= base) begin
        j = CNT_W'(i) - base;
        if (j < CNT_W'(push.cnt)) begin
          case (j[1:0])
            2'd1:    q_nxt[i] = push.item[1];
            2'd2:    q_nxt[i] = push.item[2];
            default: q_nxt[i] = push.item[0];
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
  end

  `ASSERT_CLK(a_cnt_bound, cnt_r <= CNT_W'(QUEUE_D), "queue count beyond depth")
  `ASSERT_CLK(a_no_overflow,
    ({1'b0, cnt_r} - {3'b0, pop} + {2'b0, push.cnt}) <= 4'(QUEUE_D),
    "queue overflow")
  `ASSERT_CLK(a_shift, (pop && cnt_r > 3'd1) |=> (out_item == $past(q_r[1])),
    "queue head not advanced")

endmodule

`default_nettype wire

/* src/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder, one character in per transaction, bytes out
// ----------------------------------------------------------------------------
// queueing: the bytes of a quad are written to the result queue at the edge
//   that accepts its fourth character and are presented from the queue register
// throughput: one character per cycle while in_tready is high; results leave
//   one per cycle while out_tready is high; the four-entry queue sets in_tready
// reset: synchronous active-low rst_n clears the quad position, the held
//   sextets and the result queue; no clearing pass, usable right after reset
`default_nettype none

module base64_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] symbol
  input  wire logic       in_tlast,   // final_symbol
  // result channel
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,  // [7:0] byte_out
  output      logic       out_tlast,  // last_byte
  output      logic       out_tuser   // [0] length_error
);
  import b64d_pkg::*;

  `include "assert_macros.svh"

  // quad state: position and the first three sextets of the quad
  logic [1:0]          pos_r, pos_nxt;
  logic [SEXTET_W-1:0] held_r   [3];
  logic [SEXTET_W-1:0] held_nxt [3];

  logic                in_acc;
  logic [SEXTET_W-1:0] v;
  logic [SEXTET_W-1:0] a, b, c;
  logic [BYTE_W-1:0]   b0, b1, b2;
  logic                pad_c, pad_d;
  logic [1:0]          n;
  push_t               push;
  logic [CNT_W-1:0]    level;
  res_t                out_item;

  assign in_acc = in_tvalid & in_tready;
  assign v      = sextet_of(in_tdata);
  assign a      = held_r[0];
  assign b      = held_r[1];
  assign c      = held_r[2];

  // a closing character can push three results, others at most one
  assign in_tready = (pos_r == QUAD_LAST) ? (level <= 3'd1) : (level <= 3'd3);

  // byte assembly, sextets cut to eight bits as they combine
  assign pad_c = in_tlast && (c == SEXTET_BAD);
  assign pad_d = in_tlast && (v == SEXTET_BAD);
  assign b0    = {a[5:0], 2'b00} | {5'b0, b[6:4]};
  assign b1    = pad_c ? {b[3:0], 4'b0000} : ({b[3:0], 4'b0000} | {3'b0, c[6:2]});
  assign b2    = pad_d ? {c[1:0], 6'b0} : ({c[1:0], 6'b0} | {1'b0, v});
  assign n     = 2'd3 - 2'(pad_c) - 2'(pad_d);

  always_comb begin
    pos_nxt  = pos_r;
    held_nxt = held_r;
    push     = '0;
    if (in_acc) begin
      if (pos_r != QUAD_LAST) begin
        held_nxt[pos_r] = v;
        pos_nxt         = pos_r + 2'd1;
        if (in_tlast) begin
          // message ended inside a quad: single error result
          push.cnt                     = 2'd1;
          push.item[0].byte_out        = '0;
          push.item[0].last_byte       = 1'b1;
          push.item[0].length_error    = 1'b1;
          pos_nxt                      = '0;
          held_nxt                     = '{default: '0};
        end
      end else begin
        pos_nxt                   = '0;
        push.cnt                  = n;
        push.item[0].byte_out     = b0;
        push.item[0].last_byte    = in_tlast && (n == 2'd1);
        push.item[1].byte_out     = b1;
        push.item[1].last_byte    = in_tlast && (n == 2'd2);
        push.item[2].byte_out     = b2;
        push.item[2].last_byte    = in_tlast;
        if (in_tlast) begin
          held_nxt = '{default: '0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      held_r <= '{default: '0};
    end else begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
    end
  end

  b64d_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .level     (level),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = out_item.byte_out;
  assign out_tlast = out_item.last_byte;
  assign out_tuser = out_item.length_error;

  // a final character always restarts the quad
  `ASSERT_CLK(a_final_restart, (in_acc && in_tlast) |=> (pos_r == 2'd0),
    "quad position not cleared after final character")
  // an error result carries a zero byte and closes the message
  `ASSERT_CLK(a_err_shape, (out_tvalid && out_tuser) |-> (out_tlast && out_tdata == 8'd0),
    "malformed length error result")
  // a closing character leaves at least its own results queued
  `ASSERT_CLK(a_quad_pushed, (in_acc && pos_r == QUAD_LAST) |=> (level >= 3'd1),
    "closing character produced no results")

endmodule

`default_nettype wire
